>>> hw/rtl/rwset_pkg.sv
// ============================================================================
// rwset_pkg
// Shared codes, widths and controller/datapath link types of the
// transaction read/write set tracker.
// ============================================================================
`default_nettype none

package rwset_pkg;

    // Fixed field widths
    localparam int CMD_W   = 3;
    localparam int KEY_W   = 64;
    localparam int TYPE_W  = 3;
    localparam int COUNT_W = 7;

    // Parameter defaults
    localparam int ENTRIES_DEF  = 64;
    localparam int KEY_BITS_DEF = 64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ_EXCL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd6;

    // Access type codes
    localparam logic [TYPE_W-1:0] T_NONE      = 3'd0;
    localparam logic [TYPE_W-1:0] T_READ      = 3'd1;
    localparam logic [TYPE_W-1:0] T_READ_EXCL = 3'd2;
    localparam logic [TYPE_W-1:0] T_UPDATE    = 3'd3;
    localparam logic [TYPE_W-1:0] T_DELETE    = 3'd4;
    localparam logic [TYPE_W-1:0] T_INSERT    = 3'd5;
    localparam logic [TYPE_W-1:0] T_INS_DEL   = 3'd6;

    // Controller to datapath
    typedef struct packed {
        logic start;   // capture the beat, restart the scan
        logic scan;    // advance the scan by one entry
        logic commit;  // apply the step and load the result
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic is_clear;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hw/rtl/rwset_dp.sv
// ============================================================================
// rwset_dp
// Datapath: key and type memories, one-entry-per-cycle scan, transition
// decode, tallies and result registers.
// ============================================================================
`default_nettype none

module rwset_dp #(
    parameter int ENTRIES  = rwset_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = rwset_pkg::KEY_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire rwset_pkg::t_dp_cmd        i_cmd,
    output rwset_pkg::t_dp_sts             o_sts,
    input  wire [rwset_pkg::CMD_W-1:0]     i_command,
    input  wire [rwset_pkg::KEY_W-1:0]     i_tuple_key,
    output logic [rwset_pkg::TYPE_W-1:0]   o_prior_type,
    output logic [rwset_pkg::TYPE_W-1:0]   o_new_type,
    output logic                           o_own_insert_deleted,
    output logic                           o_illegal_transition,
    output logic                           o_table_full,
    output logic                           o_written_flag,
    output logic [rwset_pkg::COUNT_W-1:0]  o_inserts_live,
    output logic [rwset_pkg::COUNT_W-1:0]  o_entries_used
);
    import rwset_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int PTR_W  = $clog2(ENTRIES + 1);
    localparam int WIDE_W = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;

    logic [KEY_BITS-1:0] key_mem  [ENTRIES];
    logic [TYPE_W-1:0]   type_mem [ENTRIES];

    logic [KEY_BITS-1:0] r_key;
    logic [CMD_W-1:0]    r_cmd;
    logic [PTR_W-1:0]    r_ptr;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [KEY_BITS-1:0] r_rd_key;
    logic [TYPE_W-1:0]   r_rd_type;
    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_slot;
    logic [TYPE_W-1:0]   r_hit_type;
    logic [PTR_W-1:0]    r_used;
    logic [PTR_W-1:0]    r_ins;
    logic                r_written;
    logic [TYPE_W-1:0]   r_prior;
    logic [TYPE_W-1:0]   r_next;
    logic                r_own;
    logic                r_ill;
    logic                r_full;

    logic                rd_en;
    logic                recording;
    logic [TYPE_W-1:0]   prior_type;
    logic [TYPE_W-1:0]   nxt_type;
    logic [TYPE_W-1:0]   cmd_type;
    logic                own_del;
    logic                illegal;
    logic                full;
    logic                do_ins;
    logic                set_written;
    logic                ins_dec;
    logic                type_we;
    logic [IDX_W-1:0]    type_waddr;
    logic [WIDE_W-1:0]   used_wide;
    logic [WIDE_W-1:0]   ins_wide;

    assign rd_en = i_cmd.scan && (r_ptr < r_used);

    assign o_sts.scan_done = r_hit || ((r_ptr >= r_used) && !r_rd_vld);
    assign o_sts.is_clear  = (r_cmd == CMD_CLEAR);

    // Scan pipeline: address, registered read, compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else if (i_cmd.start) begin
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_vld <= rd_en;
            if (rd_en) begin
                r_ptr <= r_ptr + PTR_W'(1);
            end
            if (r_rd_vld && !r_hit && (r_rd_key == r_key)) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= i_tuple_key[KEY_BITS-1:0];
            r_cmd <= i_command;
        end
        if (rd_en) begin
            r_rd_key  <= key_mem[r_ptr[IDX_W-1:0]];
            r_rd_type <= type_mem[r_ptr[IDX_W-1:0]];
            r_rd_idx  <= r_ptr[IDX_W-1:0];
        end
        if (i_cmd.scan && r_rd_vld && !r_hit && (r_rd_key == r_key)) begin
            r_hit_slot <= r_rd_idx;
            r_hit_type <= r_rd_type;
        end
    end

    // Transition decode
    always_comb begin
        recording   = (r_cmd >= CMD_READ) && (r_cmd <= CMD_DELETE);
        prior_type  = (r_hit && r_cmd != CMD_CLEAR) ? r_hit_type : T_NONE;
        nxt_type    = prior_type;
        own_del     = 1'b0;
        illegal     = 1'b0;
        full        = 1'b0;
        do_ins      = 1'b0;
        set_written = 1'b0;
        ins_dec     = 1'b0;
        case (r_cmd)
            CMD_READ:      cmd_type = T_READ;
            CMD_READ_EXCL: cmd_type = T_READ_EXCL;
            CMD_UPDATE:    cmd_type = T_UPDATE;
            CMD_INSERT:    cmd_type = T_INSERT;
            default:       cmd_type = T_DELETE;
        endcase
        if (recording) begin
            if (!r_hit) begin
                if (r_used == PTR_W'(ENTRIES)) begin
                    full = 1'b1;
                end else begin
                    do_ins   = 1'b1;
                    nxt_type = cmd_type;
                end
            end else if (r_cmd == CMD_INSERT) begin
                illegal = 1'b1;
            end else if (prior_type == T_DELETE || prior_type == T_INS_DEL) begin
                illegal = 1'b1;
            end else begin
                case (r_cmd)
                    CMD_READ_EXCL: begin
                        if (prior_type == T_READ) nxt_type = T_READ_EXCL;
                    end
                    CMD_UPDATE: begin
                        if (prior_type == T_READ || prior_type == T_READ_EXCL) begin
                            nxt_type    = T_UPDATE;
                            set_written = 1'b1;
                        end
                    end
                    CMD_DELETE: begin
                        if (prior_type == T_READ || prior_type == T_READ_EXCL) begin
                            nxt_type    = T_DELETE;
                            set_written = 1'b1;
                        end else if (prior_type == T_UPDATE) begin
                            nxt_type = T_DELETE;
                        end else if (prior_type == T_INSERT) begin
                            nxt_type = T_INS_DEL;
                            own_del  = 1'b1;
                            ins_dec  = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        type_we    = i_cmd.commit && (do_ins || (recording && r_hit && !illegal));
        type_waddr = do_ins ? r_used[IDX_W-1:0] : r_hit_slot;
    end

    // Memory write-back
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_ins) begin
            key_mem[r_used[IDX_W-1:0]] <= r_key;
        end
        if (type_we) begin
            type_mem[type_waddr] <= nxt_type;
        end
    end

    // Tallies and sticky flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_ins     <= '0;
            r_written <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_cmd == CMD_CLEAR) begin
                r_used    <= '0;
                r_ins     <= '0;
                r_written <= 1'b0;
            end else begin
                if (do_ins) begin
                    r_used <= r_used + PTR_W'(1);
                end
                if (do_ins && r_cmd == CMD_INSERT) begin
                    r_ins <= r_ins + PTR_W'(1);
                end else if (ins_dec && r_ins != '0) begin
                    r_ins <= r_ins - PTR_W'(1);
                end
                if (set_written) begin
                    r_written <= 1'b1;
                end
            end
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_prior <= prior_type;
            r_next  <= nxt_type;
            r_own   <= own_del;
            r_ill   <= illegal;
            r_full  <= full;
        end
    end

    assign used_wide = WIDE_W'(r_used);
    assign ins_wide  = WIDE_W'(r_ins);

    assign o_prior_type         = r_prior;
    assign o_new_type           = r_next;
    assign o_own_insert_deleted = r_own;
    assign o_illegal_transition = r_ill;
    assign o_table_full         = r_full;
    assign o_written_flag       = r_written;
    assign o_inserts_live       = ins_wide[COUNT_W-1:0];
    assign o_entries_used       = used_wide[COUNT_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/rwset_ctrl.sv
// ============================================================================
// rwset_ctrl
// Controller: accepts a beat, runs the scan, commits the step when the
// result register is free, and holds the output valid.
// ============================================================================
`default_nettype none

module rwset_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_stall,
    output logic                     o_valid,
    input  wire                      i_stall,
    output rwset_pkg::t_dp_cmd       o_cmd,
    input  wire rwset_pkg::t_dp_sts  i_sts
);
    import rwset_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_o_valid;
    logic       n_o_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd.start  = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.is_clear || i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (!r_o_valid || !i_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_o_valid = o_cmd.commit || (r_o_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;

endmodule

`default_nettype wire

>>> hw/rtl/txn_read_write_set_tracker.sv
// ============================================================================
// txn_read_write_set_tracker
// Associative read/write set of one transaction: tuple keys tagged with an
// access type, moved along the access-type transition graph per command.
// ============================================================================
// Usage:
//   Input channel: i_valid / o_stall carry one command beat (i_command,
//   i_tuple_key). A beat is taken when i_valid is high and o_stall is low.
//   Output channel: o_valid / i_stall carry one result beat per command.
//   Entries are filled in order and never freed one by one, so the first
//   o_entries_used slots are the live ones; a new key goes to the slot
//   numbered o_entries_used.
//   One command at a time. The scan reads the key memory one entry per
//   cycle and compares each entry once its read is registered. A clear
//   commits without waiting for the scan to finish. o_stall drops the
//   cycle after the commit, so a new beat is taken only after the
//   previous command has committed.
//   The result sits in an output register; the next beat is accepted and
//   scanned while a result still waits. If the receiver stalls, the
//   finished step waits in the commit state and the table is not touched
//   until the held result is taken.
//   Reset (synchronous, active low) empties the table, zeroes the written
//   flag and both counts; no clearing pass is needed.
// ============================================================================
`default_nettype none

module txn_read_write_set_tracker #(
    parameter int ENTRIES  = rwset_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = rwset_pkg::KEY_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire [rwset_pkg::CMD_W-1:0]     i_command,
    input  wire [rwset_pkg::KEY_W-1:0]     i_tuple_key,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic [rwset_pkg::TYPE_W-1:0]   o_prior_type,
    output logic [rwset_pkg::TYPE_W-1:0]   o_new_type,
    output logic                           o_own_insert_deleted,
    output logic                           o_illegal_transition,
    output logic                           o_table_full,
    output logic                           o_written_flag,
    output logic [rwset_pkg::COUNT_W-1:0]  o_inserts_live,
    output logic [rwset_pkg::COUNT_W-1:0]  o_entries_used
);
    import rwset_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencing: accept, scan, commit
    rwset_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    // Table, scan compare, transition decode and result registers
    rwset_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (dp_cmd),
        .o_sts                (dp_sts),
        .i_command            (i_command),
        .i_tuple_key          (i_tuple_key),
        .o_prior_type         (o_prior_type),
        .o_new_type           (o_new_type),
        .o_own_insert_deleted (o_own_insert_deleted),
        .o_illegal_transition (o_illegal_transition),
        .o_table_full         (o_table_full),
        .o_written_flag       (o_written_flag),
        .o_inserts_live       (o_inserts_live),
        .o_entries_used       (o_entries_used)
    );

    // The input side is busy in the cycle after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted twice in a row");

    // Never overwrite a result the receiver has not taken
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.commit |-> (!o_valid || !i_stall))
        else $error("commit over a held result");

    // An illegal step leaves the type unchanged
    a_illegal_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_illegal_transition) |-> (o_new_type == o_prior_type))
        else $error("illegal transition changed the type");

    // A full-table miss stores nothing
    a_full_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (o_new_type == T_NONE && o_prior_type == T_NONE))
        else $error("table full with a stored type");

endmodule

`default_nettype wire
